// ----- hw/rtl/spbt_pkg.sv -----
// spbt_pkg: shared types and constants for the fft peak-bin tracker
// no dependencies
`default_nettype none
package spbt_pkg;
    localparam int FFT_POINTS = 256;
    localparam int DATA_W  = 20;
    localparam int POWER_W = 40;
    localparam int BIN_W   = 7;
    localparam int TW_W    = 17;
    localparam logic signed [DATA_W-1:0] DATA_MAX = 20'sd524287;
    localparam logic signed [DATA_W-1:0] DATA_MIN = -20'sd524288;

    // saturation of a 22-bit butterfly sum to the 20-bit data range; the q1.15 product rounding is in spbt_back
    function automatic logic signed [DATA_W-1:0] sat20(input logic signed [DATA_W+1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 22'(DATA_MAX)) r = DATA_MAX;
        else if (v < 22'(DATA_MIN)) r = DATA_MIN;
        else r = v[DATA_W-1:0];
        return r;
    endfunction

    // q1.15 sine of angle x in radians, rounded to nearest, used at elaboration
    function automatic logic [TW_W-1:0] sine_q15(input real x);
        real v;
        v = $sin(x) * 32768.0;
        return TW_W'($rtoi(v + 0.5));
    endfunction

    // frame message from front to back
    typedef struct packed {
        logic go;
    } t_frame;
endpackage
`default_nettype wire

// ----- hw/rtl/spbt_stream_if.sv -----
// spbt_stream_if: valid/ready channel carrying a packed payload
// no dependencies
`default_nettype none
interface spbt_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/spbt_front.sv -----
// spbt_front: sample window, hop counter, frame launch
// depends on spbt_pkg
`default_nettype none
module spbt_front import spbt_pkg::*; #(
    parameter int N  = 256,
    parameter int SB = 10,
    parameter int AW = $clog2(N)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [SB-1:0] i_sample,
    output logic               o_go,
    input  wire logic          i_busy,
    input  wire logic [AW-1:0] i_rd_idx,
    output logic [SB-1:0]      o_rd_data
);
    localparam int HW = $clog2(N / 4);
    // circular window: head points at oldest sample
    // entries not yet written since reset read as zero via the fill count
    logic [SB-1:0] r_win [N];
    logic [AW-1:0] r_head;
    logic [HW-1:0] r_hop;
    logic [AW:0]   r_fill;
    logic          r_go;
    logic [SB-1:0] r_rd;
    logic          r_rd_v;
    logic [AW-1:0] rd_addr;

    assign o_ready = !i_busy && !r_go;
    assign o_go    = r_go;
    assign rd_addr = r_head + i_rd_idx;

    // window memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_win[r_head] <= i_sample;
        r_rd   <= r_win[rd_addr];
        r_rd_v <= ({1'b0, rd_addr} < r_fill);
    end
    assign o_rd_data = r_rd_v ? r_rd : '0;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_hop  <= '0;
            r_fill <= '0;
            r_go   <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (i_valid && o_ready) begin
                if (r_fill != (AW+1)'(N)) r_fill <= r_fill + 1'b1;
                r_head <= r_head + 1'b1;
                r_hop  <= r_hop + 1'b1;
                if (r_hop == HW'(N / 4 - 1)) r_go <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/spbt_back.sv -----
// spbt_back: load, iterative butterfly engine and peak scan
// depends on spbt_pkg
`default_nettype none
module spbt_back import spbt_pkg::*; #(
    parameter int N  = 256,
    parameter int SB = 10,
    parameter int AW = $clog2(N)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_go,
    output logic               o_busy,
    output logic [AW-1:0]      o_rd_idx,
    input  wire logic [SB-1:0] i_rd_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [BIN_W-1:0]   o_bin,
    output logic [POWER_W-1:0] o_power
);
    localparam int Q = N / 4;
    localparam int SW = $clog2(AW + 1);
    localparam real TW_STEP = 3.14159265358979323846 / (N / 2);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_LOAD = 7'b0000010, S_RDA = 7'b0000100,
        S_MUL  = 7'b0001000, S_WR  = 7'b0010000, S_SCAN = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    // quarter-wave sine table, fixed at elaboration
    function automatic logic [(Q+1)*TW_W-1:0] build_rom();
        logic [(Q+1)*TW_W-1:0] t;
        for (int i = 0; i <= Q; i++) t[i*TW_W +: TW_W] = sine_q15(TW_STEP * i);
        return t;
    endfunction
    localparam logic [(Q+1)*TW_W-1:0] ROM_BITS = build_rom();

    logic signed [DATA_W-1:0] r_re [N];
    logic signed [DATA_W-1:0] r_im [N];
    logic [TW_W-1:0] rom [Q+1];
    always_comb for (int i = 0; i <= Q; i++) rom[i] = ROM_BITS[i*TW_W +: TW_W];

    t_state r_st;
    logic [AW:0]   r_cnt;
    logic [SW-1:0] r_stage;
    logic [AW-1:0] r_j, r_k;
    logic signed [DATA_W-1:0] r_xr, r_xi, r_ar, r_ai;
    logic signed [TW_W:0] r_c, r_s;
    logic signed [DATA_W+TW_W+2:0] r_p1, r_p2;
    logic [BIN_W-1:0]   r_prev, r_best;
    logic [POWER_W-1:0] r_bpow;
    logic [1:0]         r_ph;
    logic signed [DATA_W-1:0] r_sr, r_si;
    logic [POWER_W-1:0] r_pw;

    logic [AW-1:0] bsz, kb, tk, ld_addr, br;
    logic signed [DATA_W+1:0] tr, ti;
    logic [POWER_W-1:0] pw;
    logic signed [2*DATA_W-1:0] sq_re, sq_im;
    logic [BIN_W-1:0] prev_c;
    logic [AW-1:0] sc_addr;

    assign bsz = AW'(1) << r_stage;
    assign kb  = r_k + bsz;
    assign tk  = AW'(r_j << (AW - 1 - r_stage));
    assign o_busy  = (r_st != S_IDLE) || i_go;
    assign o_valid = (r_st == S_OUT);
    assign o_bin   = r_best;
    assign o_power = r_bpow;
    assign o_rd_idx = r_cnt[AW-1:0];
    assign ld_addr  = AW'(r_cnt - 1'b1);
    always_comb for (int b = 0; b < AW; b++) br[b] = ld_addr[AW-1-b];
    // rounding of the two product sums
    assign tr = 22'((r_p1 + 16384) >>> 15);
    assign ti = 22'((r_p2 + 16384) >>> 15);
    // power of the registered scan operands
    assign sq_re = r_sr * r_sr;
    assign sq_im = r_si * r_si;
    assign pw = $unsigned(sq_re) + $unsigned(sq_im);
    // scan order: previous peak (out of range taken as bin one), then bins upward
    assign prev_c  = (r_prev == '0) ? BIN_W'(1) : r_prev;
    assign sc_addr = (r_cnt == '0) ? AW'(prev_c) : r_cnt[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_prev <= BIN_W'(1);
        end else begin
            case (r_st)
                S_IDLE: if (i_go) begin
                    r_st <= S_LOAD; r_cnt <= '0;
                end
                // bit-reversed load from the window
                S_LOAD: begin
                    if (r_cnt != 0) begin
                        r_re[br] <= DATA_W'(i_rd_data);
                        r_im[br] <= '0;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (AW+1)'(N)) begin
                        r_st <= S_RDA; r_stage <= '0; r_j <= '0; r_k <= '0;
                    end
                end
                // operand fetch and twiddle select
                S_RDA: begin
                    r_xr <= r_re[kb]; r_xi <= r_im[kb];
                    r_ar <= r_re[r_k]; r_ai <= r_im[r_k];
                    r_c <= (tk < AW'(Q)) ? $signed({1'b0, rom[Q - tk]})
                                         : -$signed({1'b0, rom[tk - Q]});
                    r_s <= $signed({1'b0, rom[(tk > AW'(Q)) ? (N/2 - tk) : tk]});
                    r_ph <= '0;
                    r_st <= S_MUL;
                end
                // two multiplies per cycle, summed over two phases
                S_MUL: begin
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == 0) begin
                        r_p1 <= r_xr * r_c; r_p2 <= r_xi * r_c;
                    end else begin
                        r_p1 <= r_p1 + r_xi * r_s; r_p2 <= r_p2 - r_xr * r_s;
                        r_st <= S_WR;
                    end
                end
                S_WR: begin
                    r_re[kb] <= sat20(22'(r_ar) - tr);
                    r_im[kb] <= sat20(22'(r_ai) - ti);
                    r_re[r_k] <= sat20(22'(r_ar) + tr);
                    r_im[r_k] <= sat20(22'(r_ai) + ti);
                    r_st <= S_RDA;
                    if ((AW+1)'(r_k) + (AW+1)'(bsz) * 2 < (AW+1)'(N)) begin
                        r_k <= r_k + (bsz << 1);
                    end else if (r_j + 1'b1 < bsz) begin
                        r_j <= r_j + 1'b1; r_k <= r_j + 1'b1;
                    end else if (r_stage == SW'(AW - 1)) begin
                        r_st <= S_SCAN; r_cnt <= '0;
                    end else begin
                        r_stage <= r_stage + 1'b1; r_j <= '0; r_k <= '0;
                    end
                end
                // read, power, compare pipeline; previous peak seeds the best
                S_SCAN: begin
                    if (r_cnt < (AW+1)'(N/2)) begin
                        r_sr <= r_re[sc_addr];
                        r_si <= r_im[sc_addr];
                    end
                    r_pw <= pw;
                    if (r_cnt == (AW+1)'(2)) begin
                        r_best <= prev_c;
                        r_bpow <= r_pw;
                    end else if (r_cnt > (AW+1)'(2) && r_pw > r_bpow) begin
                        r_best <= BIN_W'(r_cnt - (AW+1)'(2));
                        r_bpow <= r_pw;
                    end
                    if (r_cnt == (AW+1)'(N/2 + 1)) r_st <= S_OUT;
                    r_cnt <= r_cnt + 1'b1;
                end
                S_OUT: if (i_ready) begin
                    r_prev <= r_best; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/stft_peak_bin_tracker.sv -----
// stft_peak_bin_tracker: sliding-window fft peak-bin tracker, top level
// depends on spbt_pkg, spbt_stream_if, spbt_front, spbt_back
//
// usage: samples enter on i_in (10-bit payload); every 64th sample starts a
// 256-point fft of the last 256 samples, and one transaction on o_out gives
// {peak_bin, peak_power}. other samples give no result.
// the front accepts samples while no frame is in flight; a frame passes
// through a launch, the bit-reversed window load, 1024 butterflies in the
// single butterfly unit, and the peak scan, and then the result is valid.
// samples outside a frame are accepted without a stall.
// a stalled receiver holds the result; no sample is taken meanwhile.
// reset (synchronous, active low) empties the window, so that unwritten
// entries read as zeros through the fill count, clears the hop count,
// and sets the previous peak to bin one.
`default_nettype none
module stft_peak_bin_tracker import spbt_pkg::*; #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spbt_stream_if.sink   i_in,
    spbt_stream_if.source o_out
);
    localparam int AW = $clog2(FFT_POINTS);
    logic          go, busy;
    logic [AW-1:0] rd_idx;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [BIN_W-1:0]   bin;
    logic [POWER_W-1:0] pow;

    spbt_front #(.N(FFT_POINTS), .SB(SAMPLE_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_sample(i_in.data[SAMPLE_BITS-1:0]), .o_go(go), .i_busy(busy),
        .i_rd_idx(rd_idx), .o_rd_data(rd_data));

    spbt_back #(.N(FFT_POINTS), .SB(SAMPLE_BITS)) u_back (
        .i_clk, .i_rst_n, .i_go(go), .o_busy(busy), .o_rd_idx(rd_idx),
        .i_rd_data(rd_data), .o_valid(o_out.valid), .i_ready(o_out.ready),
        .o_bin(bin), .o_power(pow));

    assign o_out.data = {bin, pow};
endmodule
`default_nettype wire

// ----- hw/rtl/spbt_checker.sv -----
// spbt_checker: port-level checks for the tracker, bound to the top level
// depends on spbt_stream_if
`default_nettype none
module spbt_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [46:0] out_data
);
    // no sample taken while a result waits
    a_no_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("sample taken during result");
    // bin in range
    a_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_data[46:40] != 7'd0)) else $error("bin zero");
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");
endmodule
bind stft_peak_bin_tracker spbt_checker u_chk (
    .i_clk, .i_rst_n, .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready), .out_data(o_out.data));
`default_nettype wire
